[hdl/assert_macros.svh]
// assertion macros shared by the rtl of the modbus response frame checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define MRFC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mrfc assertion failed");

// next-cycle implication, disabled while reset is asserted
`define MRFC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mrfc assertion failed");

`endif

[hdl/mrfc_pkg.sv]
// package of the modbus response frame checker: frame constants, kind codes
// and the byte-wide crc-16 update; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mrfc_pkg;

  localparam int unsigned PosW = 5;

  localparam logic [PosW-1:0] PosMax    = 5'd31;
  localparam logic [PosW-1:0] Kind1Len  = 5'd21;  // crc-covered bytes, nine-register report
  localparam logic [PosW-1:0] Kind2Len  = 5'd7;   // crc-covered bytes, sensor report
  localparam logic [PosW-1:0] Kind1Full = 5'd23;
  localparam logic [PosW-1:0] Kind2Full = 5'd9;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam logic [7:0] FuncReadInput = 8'h04;
  localparam logic [7:0] CountNineReg  = 8'h12;
  localparam logic [7:0] CountSensor   = 8'h04;
  localparam logic [7:0] SensorAddrRst = 8'h08;

  // bit 0: nine-register report still possible, bit 1: sensor report still possible
  localparam logic [1:0] HdrBoth   = 2'b11;
  localparam logic [1:0] HdrNine   = 2'b01;
  localparam logic [1:0] HdrSensor = 2'b10;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_NINE_REG = 2'd1,
    KIND_SENSOR   = 2'd2
  } frame_kind_e;

  // reflected crc-16, one byte, lsb first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[hdl/mrfc_rx_if.sv]
// received byte channel of the modbus response frame checker
// valid/ready handshake; no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface mrfc_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source (output valid, rx_byte, frame_end, input ready);
  modport sink   (input valid, rx_byte, frame_end, output ready);
endinterface

`default_nettype wire

[hdl/mrfc_res_if.sv]
// result channel of the modbus response frame checker
// valid/ready handshake; no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface mrfc_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] frame_kind;
  logic       crc_ok;
  logic [7:0] source_address;

  modport source (output valid, frame_kind, crc_ok, source_address, input ready);
  modport sink   (input valid, frame_kind, crc_ok, source_address, output ready);
endinterface

`default_nettype wire

[hdl/mrfc_cfg_if.sv]
// configuration write channel of the modbus response frame checker
// carries the sensor address register; no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface mrfc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] sensor_address;

  modport source (output valid, sensor_address, input ready);
  modport sink   (input valid, sensor_address, output ready);
endinterface

`default_nettype wire

[hdl/modbus_response_frame_checker.sv]
// top level of the modbus response frame checker
// depends on mrfc_pkg, mrfc_rx_if, mrfc_res_if, mrfc_cfg_if and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

// Checks Modbus RTU response frames one received byte per item. The block tracks
// the byte position, a reflected crc-16 (poly a001, seed ffff) and which of two
// frame kinds the header still allows: a nine-register report (any address,
// function 04, count 12, crc over 21 bytes) or a sensor report (the configured
// sensor address, function 04, count 04, crc over 7 bytes). Bytes past the crc are
// ignored and the position counter saturates at 31. An item with frame_end set
// yields one result: kind (0 for unmatched or too short), crc verdict and the
// address byte; other items yield nothing. Throughput is one item per clock but for the
// stall below; an item is taken into the input register and from there reaches the
// result register, so a result shows on res_o once its last byte leaves the input register.
// Only a last byte waits while an earlier result is still held; other bytes go on.
// The path that sets the clock is the eight-step crc update from the input
// register into the crc register. The sensor address is written through the
// config channel, which is always ready, and must only be changed while no frame
// is in flight.
module modbus_response_frame_checker (
  input  wire        clk_i,
  input  wire        rst_ni,
  mrfc_rx_if.sink    rx_i,
  mrfc_cfg_if.sink   cfg_i,
  mrfc_res_if.source res_o
);

  `include "assert_macros.svh"

  // config register
  logic [7:0] sensor_addr_q;

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_end_q;

  // per-frame state
  logic [mrfc_pkg::PosW-1:0] pos_q, pos_d;
  logic [15:0]               crc_q, crc_d;
  logic [1:0]                hdr_q, hdr_d;
  logic [7:0]                first_q, first_d;
  logic [7:0]                crc_lo_q, crc_lo_d;
  logic                      verdict_q, verdict_d;

  // result register
  logic                  res_valid_q;
  mrfc_pkg::frame_kind_e res_kind_q, kind_d;
  logic                  res_ok_q;
  logic [7:0]            res_addr_q;

  logic                      advance;
  logic [mrfc_pkg::PosW-1:0] n_len;

  // the stage moves unless a last byte finds the result slot full and stalled
  assign advance    = in_valid_q && (!in_end_q || !res_valid_q || res_o.ready);
  assign rx_i.ready = !in_valid_q || advance;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sensor_addr_q <= mrfc_pkg::SensorAddrRst;
    end else if (cfg_i.valid) begin
      sensor_addr_q <= cfg_i.sensor_address;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.rx_byte;
      in_end_q  <= rx_i.frame_end;
    end
  end

  // state update for the byte held in the input register
  always_comb begin
    hdr_d     = hdr_q;
    first_d   = first_q;
    crc_d     = crc_q;
    crc_lo_d  = crc_lo_q;
    verdict_d = verdict_q;
    n_len     = '0;
    kind_d    = mrfc_pkg::KIND_NONE;

    // header match on the first three bytes
    if (pos_q == 5'd0) begin
      first_d = in_byte_q;
      if (in_byte_q != sensor_addr_q) begin
        hdr_d = hdr_q & mrfc_pkg::HdrNine;
      end
    end else if (pos_q == 5'd1) begin
      if (in_byte_q != mrfc_pkg::FuncReadInput) begin
        hdr_d = 2'b00;
      end
    end else if (pos_q == 5'd2) begin
      if (in_byte_q != mrfc_pkg::CountNineReg) begin
        hdr_d = hdr_d & mrfc_pkg::HdrSensor;
      end
      if (in_byte_q != mrfc_pkg::CountSensor) begin
        hdr_d = hdr_d & mrfc_pkg::HdrNine;
      end
    end

    // the first seven bytes are always covered, the longer kind covers 21
    if (pos_q < mrfc_pkg::Kind2Len || (pos_q < mrfc_pkg::Kind1Len && hdr_d[0])) begin
      crc_d = mrfc_pkg::crc16_byte(crc_q, in_byte_q);
    end

    // trailing crc, low byte first; the running crc is final by then
    if (hdr_d[0]) begin
      n_len = mrfc_pkg::Kind1Len;
    end else if (hdr_d[1]) begin
      n_len = mrfc_pkg::Kind2Len;
    end
    if (n_len != '0) begin
      if (pos_q == n_len) begin
        crc_lo_d = in_byte_q;
      end else if (pos_q == n_len + 5'd1) begin
        verdict_d = (crc_q == {in_byte_q, crc_lo_q});
      end
    end

    pos_d = (pos_q < mrfc_pkg::PosMax) ? pos_q + 5'd1 : pos_q;

    // too-short frames fall through to unmatched
    if (hdr_d[0] && pos_d >= mrfc_pkg::Kind1Full) begin
      kind_d = mrfc_pkg::KIND_NINE_REG;
    end else if (hdr_d[1] && pos_d >= mrfc_pkg::Kind2Full) begin
      kind_d = mrfc_pkg::KIND_SENSOR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      crc_q     <= mrfc_pkg::CrcInit;
      hdr_q     <= mrfc_pkg::HdrBoth;
      first_q   <= '0;
      crc_lo_q  <= '0;
      verdict_q <= 1'b0;
    end else if (advance) begin
      if (in_end_q) begin
        // frame done: back to the start-of-frame state
        pos_q     <= '0;
        crc_q     <= mrfc_pkg::CrcInit;
        hdr_q     <= mrfc_pkg::HdrBoth;
        first_q   <= '0;
        crc_lo_q  <= '0;
        verdict_q <= 1'b0;
      end else begin
        pos_q     <= pos_d;
        crc_q     <= crc_d;
        hdr_q     <= hdr_d;
        first_q   <= first_d;
        crc_lo_q  <= crc_lo_d;
        verdict_q <= verdict_d;
      end
    end
  end

  // result register, loaded only by the last byte of a frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance && in_end_q) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_end_q) begin
      res_kind_q <= kind_d;
      res_ok_q   <= (kind_d != mrfc_pkg::KIND_NONE) && verdict_d;
      res_addr_q <= first_d;
    end
  end

  assign res_o.valid          = res_valid_q;
  assign res_o.frame_kind     = res_kind_q;
  assign res_o.crc_ok         = res_ok_q;
  assign res_o.source_address = res_addr_q;

  // a frame end always lands in the result register
  `MRFC_ASSERT_NXT(a_end_gives_result, advance && in_end_q, res_valid_q)
  // a frame end leaves clean per-frame state
  `MRFC_ASSERT_NXT(a_end_clears, advance && in_end_q,
                   pos_q == '0 && crc_q == mrfc_pkg::CrcInit && hdr_q == mrfc_pkg::HdrBoth)
  // at the start of a frame both kinds are still open
  `MRFC_ASSERT_IMP(a_start_hdr, pos_q == '0, hdr_q == mrfc_pkg::HdrBoth)
  // input is only held off by a full, stalled pipeline
  `MRFC_ASSERT_IMP(a_ready_stall, !rx_i.ready, in_valid_q && res_valid_q && !res_o.ready)
  // a passing crc only comes with a recognized frame
  `MRFC_ASSERT_IMP(a_ok_kind, res_valid_q && res_ok_q, res_kind_q != mrfc_pkg::KIND_NONE)

endmodule

`default_nettype wire
